### hw/rtl/ir_pulse_space_frame_decoder_assert.svh
// assertion macros used by the ir frame decoder top module
`ifndef IR_PULSE_SPACE_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_SPACE_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IPSFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ipsfd assertion failed");

// next-cycle implication, checked out of reset
`define IPSFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ipsfd assertion failed");

`endif

### hw/rtl/ipsfd_pkg.sv
// types and constants of the ir pulse/space frame decoder
`default_nettype none

package ipsfd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusCheckFail = 2'd1,
    StatusReject    = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CfgBitThreshold      = 2'd0;
  localparam logic [1:0] CfgPreambleThreshold = 2'd1;
  localparam logic [1:0] CfgMinFrameWords     = 2'd2;

  // register reset values
  localparam logic [15:0] BitThresholdReset      = 16'd1200;
  localparam logic [31:0] PreambleThresholdReset = 32'h0002_0000;
  localparam logic [6:0]  MinFrameWordsReset     = 7'd68;

  // frame layout
  localparam logic [6:0] FirstBitWord = 7'd4;
  localparam logic [6:0] LastBitWord  = 7'd66;
  localparam int unsigned CountMax    = 127;
  localparam logic [7:0] CheckSum     = 8'hFF;

  typedef struct packed {
    logic [15:0] bit_threshold;
    logic [31:0] preamble_threshold;
    logic [6:0]  min_frame_words;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  word_count;
    logic [31:0] code_acc;
    logic        preamble_ok;
  } read_state_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] code_word;
    logic [7:0]  data_byte;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/ipsfd_if.sv
// valid/ready channel interfaces of the ir frame decoder
`default_nettype none

// duration word channel
interface ipsfd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] duration_word;
  logic        last_of_read;

  modport source (output valid, output duration_word, output last_of_read, input ready);
  modport sink   (input valid, input duration_word, input last_of_read, output ready);
endinterface

// decoded result channel
interface ipsfd_out_if;
  logic               valid;
  logic               ready;
  ipsfd_pkg::status_e status;
  logic [31:0]        code_word;
  logic [7:0]         data_byte;

  modport source (output valid, output status, output code_word, output data_byte,
                  input ready);
  modport sink   (input valid, input status, input code_word, input data_byte,
                  output ready);
endinterface

// configuration write channel
interface ipsfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/ipsfd_step.sv
// per-word decode: next read state and end-of-read result
`default_nettype none

module ipsfd_step #(
  parameter int unsigned MAX_READ_WORDS = 128
) (
  input  ipsfd_pkg::cfg_t        cfg_i,
  input  ipsfd_pkg::read_state_t state_i,
  input  logic [31:0]            word_i,
  input  logic                   last_i,
  output ipsfd_pkg::read_state_t state_o,
  output ipsfd_pkg::result_t     result_o
);

  localparam int unsigned LimitRaw = MAX_READ_WORDS - 1;
  localparam logic [6:0] CountLimit =
    (LimitRaw < ipsfd_pkg::CountMax) ? 7'(LimitRaw) : 7'(ipsfd_pkg::CountMax);

  logic [6:0]  pos;
  logic        pre_ok;
  logic        bit_slot;
  logic [6:0]  slot_offset;
  logic [4:0]  bit_no;
  logic [31:0] code_next;
  logic [7:0]  total;
  logic        rejected;
  logic [7:0]  data_field;
  logic [7:0]  check_field;

  assign pos = state_i.word_count;

  // preamble is judged on word 0 only
  assign pre_ok = (pos == 7'd0) ? (word_i > cfg_i.preamble_threshold) : state_i.preamble_ok;

  // even space words 4..66 carry one code bit, msb first
  assign bit_slot    = (pos >= ipsfd_pkg::FirstBitWord) && (pos <= ipsfd_pkg::LastBitWord) &&
                       !pos[0];
  assign slot_offset = pos - ipsfd_pkg::FirstBitWord;
  assign bit_no      = 5'd31 - slot_offset[5:1];

  always_comb begin
    code_next = state_i.code_acc;
    if (bit_slot && (word_i > {16'd0, cfg_i.bit_threshold})) begin
      code_next[bit_no] = 1'b1;
    end
  end

  // length check counts the current word
  assign total    = {1'b0, pos} + 8'd1;
  assign rejected = (total < {1'b0, cfg_i.min_frame_words}) || !pre_ok;

  assign data_field  = code_next[15:8];
  assign check_field = code_next[7:0];

  // result fields
  always_comb begin
    result_o.status    = ipsfd_pkg::StatusReject;
    result_o.code_word = 32'd0;
    result_o.data_byte = 8'd0;
    if (!rejected) begin
      result_o.code_word = code_next;
      if ((data_field ^ check_field) == ipsfd_pkg::CheckSum) begin
        result_o.status    = ipsfd_pkg::StatusOk;
        result_o.data_byte = data_field;
      end else begin
        result_o.status = ipsfd_pkg::StatusCheckFail;
      end
    end
  end

  // next state: saturating count, cleared at end of read
  always_comb begin
    if (last_i) begin
      state_o = '0;
    end else begin
      state_o.word_count  = (pos < CountLimit) ? pos + 7'd1 : pos;
      state_o.code_acc    = code_next;
      state_o.preamble_ok = pre_ok;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ir_pulse_space_frame_decoder.sv
// an accepted word goes to the input register; a word ending a read is decoded into the output register
// throughput: one duration word per cycle, set by the single decode stage, but
// a word that ends a read waits in the input register while the result is unread
// reset clears the read state, both valid flags and loads the register defaults
// configuration writes are taken every cycle
`default_nettype none

`include "ir_pulse_space_frame_decoder_assert.svh"

module ir_pulse_space_frame_decoder #(
  parameter int unsigned MAX_READ_WORDS = 128
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ipsfd_in_if.sink          in_i,
  ipsfd_out_if.source       out_o,
  ipsfd_cfg_if.sink         cfg_i
);

  ipsfd_pkg::cfg_t        cfg_q;
  ipsfd_pkg::read_state_t state_q, state_d;
  ipsfd_pkg::result_t     result_d, result_q;

  logic        s1_valid_q;
  logic [31:0] s1_word_q;
  logic        s1_last_q;
  logic        out_valid_q;
  logic        out_free;
  logic        advance;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_threshold      <= ipsfd_pkg::BitThresholdReset;
      cfg_q.preamble_threshold <= ipsfd_pkg::PreambleThresholdReset;
      cfg_q.min_frame_words    <= ipsfd_pkg::MinFrameWordsReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        ipsfd_pkg::CfgBitThreshold:      cfg_q.bit_threshold      <= cfg_i.wdata[15:0];
        ipsfd_pkg::CfgPreambleThreshold: cfg_q.preamble_threshold <= cfg_i.wdata;
        ipsfd_pkg::CfgMinFrameWords:     cfg_q.min_frame_words    <= cfg_i.wdata[6:0];
        default: ;
      endcase
    end
  end

  // handshake between input register, decode stage and output register
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_word_q <= in_i.duration_word;
      s1_last_q <= in_i.last_of_read;
    end
  end

  // decode logic
  ipsfd_step #(
    .MAX_READ_WORDS (MAX_READ_WORDS)
  ) u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .word_i   (s1_word_q),
    .last_i   (s1_last_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // read state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = result_q.status;
  assign out_o.code_word = result_q.code_word;
  assign out_o.data_byte = result_q.data_byte;

  // checks
  `IPSFD_ASSERT_NOW(a_reject_clears, clk_i, rst_ni,
    out_valid_q && (result_q.status == ipsfd_pkg::StatusReject),
    (result_q.code_word == 32'd0) && (result_q.data_byte == 8'd0))
  `IPSFD_ASSERT_NOW(a_data_only_ok, clk_i, rst_ni,
    out_valid_q && (result_q.status != ipsfd_pkg::StatusOk),
    result_q.data_byte == 8'd0)
  `IPSFD_ASSERT_NOW(a_ok_is_complement, clk_i, rst_ni,
    out_valid_q && (result_q.status == ipsfd_pkg::StatusOk),
    (result_q.data_byte == result_q.code_word[15:8]) &&
    ((result_q.data_byte ^ result_q.code_word[7:0]) == ipsfd_pkg::CheckSum))
  `IPSFD_ASSERT_NEXT(a_read_end_clears, clk_i, rst_ni,
    advance && s1_last_q,
    (state_q.word_count == 7'd0) && (state_q.code_acc == 32'd0) && !state_q.preamble_ok)
  `IPSFD_ASSERT_NEXT(a_result_held, clk_i, rst_ni,
    out_valid_q && !out_o.ready,
    out_valid_q && $stable(result_q))

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench of the ir pulse/space frame decoder
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReadWords = 128;
  localparam int unsigned CountLimit   =
      (MaxReadWords - 1 < ipsfd_pkg::CountMax) ? MaxReadWords - 1 : ipsfd_pkg::CountMax;
  localparam int ItemsTarget   = 1400;
  localparam int FramesTarget  = 24;
  localparam int CycleLimit    = 400_000;

  typedef struct packed {
    logic [31:0] dur;
    logic        last;
  } ir_word_t;

  logic clk_i;
  logic rst_ni;

  ipsfd_in_if  word_if ();
  ipsfd_out_if res_if ();
  ipsfd_cfg_if cfg_if ();

  ir_pulse_space_frame_decoder #(
    .MAX_READ_WORDS(MaxReadWords)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (word_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // pending duration words and expected frame results
  ir_word_t           duration_q[$];
  ipsfd_pkg::result_t decoded_q[$];

  // predictor copy of the registers and the read state
  logic [15:0] bit_thr_q;
  logic [31:0] pre_thr_q;
  logic [6:0]  min_words_q;
  logic [6:0]  rd_count;
  logic [31:0] rd_code;
  logic        rd_pre_ok;

  // settings the stimulus is shaped for
  logic [15:0] gen_bit;
  logic [31:0] gen_pre;
  logic [6:0]  gen_min;

  int words_shown, words_taken, cfg_taken;
  int words_pushed, reads_pushed;
  int word_gap_pct, res_stall_pct;
  int word_gap, res_stall;
  int n_errors, n_ok, n_fail, n_rej;
  int cycle_cnt;
  ipsfd_pkg::result_t want;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // known values on every input from time zero
  initial begin
    word_if.valid         = 1'b0;
    word_if.duration_word = '0;
    word_if.last_of_read  = 1'b0;
    res_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.addr           = ipsfd_pkg::CfgBitThreshold;
    cfg_if.wdata          = '0;
  end

  // predict the result of one accepted duration word
  function automatic void decode_word(input logic [31:0] w, input logic last);
    logic [6:0]  pos;
    int unsigned total;
    int unsigned bitno;
    ipsfd_pkg::result_t r;
    pos = rd_count;
    if (pos == 0) rd_pre_ok = (w > pre_thr_q);
    if (pos >= ipsfd_pkg::FirstBitWord && pos <= ipsfd_pkg::LastBitWord && !pos[0]) begin
      bitno = 31 - ((pos - ipsfd_pkg::FirstBitWord) >> 1);
      if (w > {16'h0, bit_thr_q}) rd_code[bitno] = 1'b1;
    end
    total = pos + 1;
    if (pos < CountLimit) rd_count = 7'(pos + 1);
    if (last) begin
      if (total < min_words_q || !rd_pre_ok) begin
        r = '{status: ipsfd_pkg::StatusReject, code_word: '0, data_byte: '0};
      end else if ((rd_code[15:8] ^ rd_code[7:0]) == ipsfd_pkg::CheckSum) begin
        r = '{status: ipsfd_pkg::StatusOk, code_word: rd_code, data_byte: rd_code[15:8]};
      end else begin
        r = '{status: ipsfd_pkg::StatusCheckFail, code_word: rd_code, data_byte: '0};
      end
      decoded_q.push_back(r);
      rd_count  = '0;
      rd_code   = '0;
      rd_pre_ok = 1'b0;
    end
  endfunction

  // duration word driver
  always @(negedge clk_i) begin
    if (word_if.valid && words_taken != words_shown) begin
      // request still waiting, hold it
    end else if (word_gap > 0) begin
      word_gap--;
      word_if.valid <= 1'b0;
    end else if (duration_q.size() > 0) begin
      if (word_gap_pct > 0 && $urandom_range(99, 0) < word_gap_pct) begin
        word_gap = $urandom_range(19, 1) - 1;
        word_if.valid <= 1'b0;
      end else begin
        word_if.valid         <= 1'b1;
        word_if.duration_word <= duration_q[0].dur;
        word_if.last_of_read  <= duration_q[0].last;
        words_shown++;
      end
    end else begin
      word_if.valid <= 1'b0;
    end
  end

  // result ready with stall bursts
  always @(negedge clk_i) begin
    if (res_stall > 0) begin
      res_stall--;
      res_if.ready <= 1'b0;
    end else if (res_stall_pct > 0 && $urandom_range(99, 0) < res_stall_pct) begin
      res_stall = $urandom_range(19, 1) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // monitor: check results, predict on accepted words, track register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (decoded_q.size() == 0) begin
          n_errors++;
          $display("%0t: result with none expected: status %0d code %h data %h", $time,
                   res_if.status, res_if.code_word, res_if.data_byte);
        end else begin
          want = decoded_q.pop_front();
          if (res_if.status !== want.status) begin
            n_errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     res_if.status);
          end
          if (res_if.code_word !== want.code_word) begin
            n_errors++;
            $display("%0t: code_word expected %h actual %h", $time, want.code_word,
                     res_if.code_word);
          end
          if (res_if.data_byte !== want.data_byte) begin
            n_errors++;
            $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                     res_if.data_byte);
          end
          case (want.status)
            ipsfd_pkg::StatusOk:        n_ok++;
            ipsfd_pkg::StatusCheckFail: n_fail++;
            default:                    n_rej++;
          endcase
        end
      end
      if (word_if.valid && word_if.ready) begin
        decode_word(word_if.duration_word, word_if.last_of_read);
        void'(duration_q.pop_front());
        words_taken++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.addr)
          ipsfd_pkg::CfgBitThreshold:      bit_thr_q   = cfg_if.wdata[15:0];
          ipsfd_pkg::CfgPreambleThreshold: pre_thr_q   = cfg_if.wdata;
          ipsfd_pkg::CfgMinFrameWords:     min_words_q = cfg_if.wdata[6:0];
          default: ;
        endcase
        cfg_taken++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // register write over the configuration channel
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    int target;
    target = cfg_taken + 1;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= val;
    do @(negedge clk_i); while (cfg_taken < target);
    cfg_if.valid <= 1'b0;
  endtask

  // wait until every word is taken and every result has come back
  task automatic wait_drained();
    while (duration_q.size() != 0 || words_taken != words_shown || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] b, input logic [31:0] p, input logic [6:0] m);
    wait_drained();
    write_reg(ipsfd_pkg::CfgBitThreshold, {16'h0, b});
    write_reg(ipsfd_pkg::CfgPreambleThreshold, p);
    write_reg(ipsfd_pkg::CfgMinFrameWords, {25'h0, m});
    gen_bit = b;
    gen_pre = p;
    gen_min = m;
  endtask

  function automatic logic [31:0] noise_word();
    case ($urandom_range(3, 0))
      0:       noise_word = $urandom();
      1:       noise_word = $urandom_range(4000, 0);
      2:       noise_word = '0;
      default: noise_word = '1;
    endcase
  endfunction

  // space word that decodes to the given bit, often right at the threshold
  function automatic logic [31:0] space_word(input logic one, input logic [15:0] thr);
    logic [31:0] t;
    t = {16'h0, thr};
    if (one) begin
      case ($urandom_range(2, 0))
        0:       space_word = t + 1;
        1:       space_word = $urandom_range(t + 5000, t + 1);
        default: space_word = $urandom_range(32'hFFFF_FFFF, t + 1);
      endcase
    end else begin
      case ($urandom_range(2, 0))
        0:       space_word = t;
        1:       space_word = $urandom_range(t, 0);
        default: space_word = '0;
      endcase
    end
  endfunction

  // preamble mostly above the threshold, sometimes at or below it
  function automatic logic [31:0] preamble_word(input logic [31:0] thr);
    if (thr != '1 && $urandom_range(9, 0) != 0) begin
      if ($urandom_range(1, 0) == 0) preamble_word = thr + 1;
      else preamble_word = $urandom_range(32'hFFFF_FFFF, thr + 1);
    end else begin
      preamble_word = $urandom_range(thr, 0);
    end
  endfunction

  task automatic push_word(input logic [31:0] w, input logic last);
    duration_q.push_back('{dur: w, last: last});
    words_pushed++;
    if (last) reads_pushed++;
  endtask

  // one read laid out as a frame carrying the given code
  task automatic push_frame(input logic [31:0] code, input int len);
    logic [31:0] w;
    for (int p = 0; p < len; p++) begin
      if (p == 0) w = preamble_word(gen_pre);
      else if (p >= 4 && p <= 66 && p % 2 == 0) w = space_word(code[31 - (p - 4) / 2], gen_bit);
      else w = noise_word();
      push_word(w, p == len - 1);
    end
  endtask

  // one random read: mostly well-formed frames, the rest short, long or noise
  task automatic push_read();
    int          kind;
    int          len;
    logic [31:0] code;
    kind = $urandom_range(99, 0);
    code = $urandom();
    if ($urandom_range(9, 0) < 7) code[7:0] = ~code[15:8];
    if (kind < 60) begin
      case ($urandom_range(9, 0))
        0:       len = 66 + $urandom_range(1, 0);
        1, 2:    len = 68 + $urandom_range(6, 1);
        default: len = 68;
      endcase
      if (gen_min > len) len = gen_min + $urandom_range(2, 0);
      push_frame(code, len);
    end else if (kind < 80) begin
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) push_word(noise_word(), i == len - 1);
    end else if (kind < 90) begin
      // runs the word counter into saturation
      push_frame(code, $urandom_range(140, 128));
    end else begin
      len = $urandom_range(80, 1);
      for (int i = 0; i < len; i++) push_word(noise_word(), i == len - 1);
    end
  endtask

  task automatic run_phase(input int budget);
    int start;
    start = words_pushed;
    while (words_pushed - start < budget) push_read();
  endtask

  // stimulus sequence
  initial begin
    bit_thr_q     = ipsfd_pkg::BitThresholdReset;
    pre_thr_q     = ipsfd_pkg::PreambleThresholdReset;
    min_words_q   = ipsfd_pkg::MinFrameWordsReset;
    rd_count      = '0;
    rd_code       = '0;
    rd_pre_ok     = 1'b0;
    word_gap_pct  = 20;
    res_stall_pct = 20;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: short reads with a one-word minimum
    set_config(16'd1200, 32'h0002_0000, 7'd1);
    push_word(32'hFFFF_FFFF, 1'b1);           // lone preamble, empty code
    push_word(32'h0000_0000, 1'b1);           // preamble far too low
    push_word(32'h0002_0000, 1'b1);           // preamble equal to threshold
    push_word(32'h0002_0001, 1'b0);           // preamble just above
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'd1200, 1'b0);                // pulse word, no bit
    push_word(32'd1201, 1'b0);                // first space just above: bit 31 set
    push_word(32'd1200, 1'b1);                // odd position, ignored
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h5555_5555, 1'b0);
    push_word(32'hAAAA_AAAA, 1'b0);
    push_word(32'h0000_0001, 1'b0);
    push_word(32'd1200, 1'b0);                // space at threshold: bit 31 clear
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);           // bit 30 set
    push_word(32'h0002_0001, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);

    // reset values, moderate idling
    set_config(16'd1200, 32'h0002_0000, 7'd68);
    word_gap_pct  = 30;
    res_stall_pct = 30;
    run_phase(300);

    // all zero: every read long enough, every space above zero is a one
    set_config(16'd0, 32'h0, 7'd0);
    word_gap_pct  = 10;
    res_stall_pct = 40;
    run_phase(200);

    // highest bit threshold, highest passable preamble threshold and longest minimum
    set_config(16'hFFFF, 32'hFFFF_FFFE, 7'd127);
    word_gap_pct  = 40;
    res_stall_pct = 10;
    run_phase(300);

    // preamble can never pass
    set_config(16'hFFFF, 32'hFFFF_FFFF, 7'd1);
    word_gap_pct  = 20;
    res_stall_pct = 20;
    run_phase(60);

    // random setting
    set_config(16'($urandom_range(16'hFFFF, 0)), $urandom_range(32'h00FF_FFFF, 0),
               7'($urandom_range(127, 1)));
    word_gap_pct  = 25;
    res_stall_pct = 25;
    run_phase(250);

    // reset values again, no idling on either side
    set_config(16'd1200, 32'h0002_0000, 7'd68);
    word_gap_pct  = 0;
    res_stall_pct = 0;
    run_phase(200);
    while (words_pushed < ItemsTarget || reads_pushed < FramesTarget) push_read();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      n_errors += decoded_q.size();
      $display("%0t: %0d expected results never came", $time, decoded_q.size());
    end
    $display("%0d duration words in %0d reads over 7 register settings, %0d writes",
             words_taken, reads_pushed, cfg_taken);
    $display("frames seen: %0d decoded, %0d complement failures, %0d rejected",
             n_ok, n_fail, n_rej);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/ipsfd_pkg.sv
hw/rtl/ipsfd_if.sv
hw/rtl/ipsfd_step.sv
hw/rtl/ir_pulse_space_frame_decoder.sv
tb/sv/tb.sv
